@@ design/dsi_pkg.sv @@
// Shared types and constants of the damped spring impulse core.
package dsi_pkg;

	// Root extraction: one leading zero pair added to the 66-bit sum of squares
	localparam int unsigned SQRT_STEPS     = 34;
	localparam int unsigned SQRT_PER_STAGE = 2;
	localparam int unsigned SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

	// Direction division: 18 quotient bits, the top one always clear
	localparam int unsigned DIV_STEPS     = 18;
	localparam int unsigned DIV_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

	// Register indexes
	localparam logic [2:0] REG_REST_H    = 3'd0;
	localparam logic [2:0] REG_REST_V    = 3'd1;
	localparam logic [2:0] REG_REST_D    = 3'd2;
	localparam logic [2:0] REG_STIFFNESS = 3'd3;
	localparam logic [2:0] REG_DAMPING   = 3'd4;
	localparam logic [2:0] REG_MASS      = 3'd5;
	localparam logic [2:0] REG_INV_MASS  = 3'd6;

	// Spring kinds
	localparam logic [1:0] KIND_HORIZ    = 2'd0;
	localparam logic [1:0] KIND_VERT     = 2'd1;
	localparam logic [1:0] KIND_DIAG     = 2'd2;
	localparam logic [1:0] KIND_DIAG_NEG = 2'd3;

	// Reciprocal of ten for 32-bit operands, used with a right shift of 35
	localparam logic [63:0] RECIP10       = 64'h0000_0000_CCCC_CCCD;
	localparam int unsigned RECIP10_SHIFT = 35;

	typedef struct packed {
		logic        [1:0]  kind;
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] first_vel_x;
		logic signed [31:0] first_vel_y;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] second_vel_x;
		logic signed [31:0] second_vel_y;
	} dsi_in_t;

	typedef struct packed {
		logic signed [31:0] new_first_vel_x;
		logic signed [31:0] new_first_vel_y;
		logic signed [31:0] new_second_vel_x;
		logic signed [31:0] new_second_vel_y;
		logic               coincident;
	} dsi_out_t;

	typedef struct packed {
		logic signed [31:0] v1x;
		logic signed [31:0] v1y;
		logic signed [31:0] v2x;
		logic signed [31:0] v2y;
	} dsi_vel_t;

	// What an item carries alongside the root and divide pipelines
	typedef struct packed {
		logic        [1:0]  kind;
		logic        [32:0] ax;
		logic        [32:0] ay;
		logic               sx;
		logic               sy;
		logic signed [32:0] dvx;
		logic signed [32:0] dvy;
		dsi_vel_t           vel;
	} dsi_side_t;

	typedef struct packed {
		logic [30:0] rest_h;
		logic [30:0] rest_v;
		logic [30:0] rest_d;
		logic [28:0] stiff;
		logic [22:0] damp;
		logic [30:0] mass;
		logic [30:0] inv;
	} dsi_cfg_t;

endpackage

@@ design/dsi_isqrt.sv @@
// Pipelined integer square root of the squared spring length, two digits a stage.
module dsi_isqrt import dsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  logic [65:0] radicand,
	input  dsi_side_t   in_side,
	output logic        out_vld,
	output logic [32:0] root,
	output dsi_side_t   out_side
);

	localparam int unsigned NST = SQRT_STAGES;

	logic [NST-1:0] vld_s;
	logic [67:0]    rad_s  [NST];
	logic [36:0]    rem_s  [NST];
	logic [33:0]    root_s [NST];
	dsi_side_t      side_s [NST];

	logic [36:0]    rem_nx  [NST];
	logic [33:0]    root_nx [NST];

	// One restoring step per digit pair
	always_comb begin
		logic [67:0] rad_c;
		logic [36:0] rem_c;
		logic [33:0] root_c;
		logic [36:0] cur;
		logic [36:0] trial;
		for (int st = 0; st < NST; st++) begin
			rad_c  = {2'b00, radicand};
			rem_c  = '0;
			root_c = '0;
			if (st != 0) begin
				rad_c  = rad_s[st-1];
				rem_c  = rem_s[st-1];
				root_c = root_s[st-1];
			end
			for (int j = 0; j < SQRT_PER_STAGE; j++) begin
				cur   = {rem_c[34:0],
					rad_c[2*(SQRT_STEPS-1-st*SQRT_PER_STAGE-j) +: 2]};
				trial = {1'b0, root_c, 2'b01};
				if (cur >= trial) begin
					rem_c  = cur - trial;
					root_c = {root_c[32:0], 1'b1};
				end else begin
					rem_c  = cur;
					root_c = {root_c[32:0], 1'b0};
				end
			end
			rem_nx[st]  = rem_c;
			root_nx[st] = root_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int st = 0; st < NST; st++) begin
				rem_s[st]  <= rem_nx[st];
				root_s[st] <= root_nx[st];
				if (st == 0) begin
					rad_s[st]  <= {2'b00, radicand};
					side_s[st] <= in_side;
				end else begin
					rad_s[st]  <= rad_s[st-1];
					side_s[st] <= side_s[st-1];
				end
			end
		end
	end

	assign out_vld  = vld_s[NST-1];
	assign root     = root_s[NST-1][32:0];
	assign out_side = side_s[NST-1];

endmodule

@@ design/dsi_div.sv @@
// Pipelined restoring divide of both offsets by the length, two quotient bits a stage.
module dsi_div import dsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  logic [32:0] in_len,
	input  dsi_side_t   in_side,
	output logic        out_vld,
	output logic [16:0] qx,
	output logic [16:0] qy,
	output logic [32:0] len,
	output dsi_side_t   out_side
);

	localparam int unsigned NST = DIV_STAGES;

	logic [NST-1:0] vld_s;
	logic [48:0]    remx_s [NST];
	logic [48:0]    remy_s [NST];
	logic [17:0]    qx_s   [NST];
	logic [17:0]    qy_s   [NST];
	logic [32:0]    len_s  [NST];
	dsi_side_t      side_s [NST];

	logic [48:0]    remx_nx [NST];
	logic [48:0]    remy_nx [NST];
	logic [17:0]    qx_nx   [NST];
	logic [17:0]    qy_nx   [NST];

	always_comb begin
		logic [48:0] rx;
		logic [48:0] ry;
		logic [17:0] bx;
		logic [17:0] by;
		logic [32:0] lc;
		logic [50:0] trial;
		for (int st = 0; st < NST; st++) begin
			rx = {in_side.ax, 16'h0000};
			ry = {in_side.ay, 16'h0000};
			bx = '0;
			by = '0;
			lc = in_len;
			if (st != 0) begin
				rx = remx_s[st-1];
				ry = remy_s[st-1];
				bx = qx_s[st-1];
				by = qy_s[st-1];
				lc = len_s[st-1];
			end
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				trial = {18'h00000, lc} << (DIV_STEPS-1-st*DIV_PER_STAGE-j);
				if ({2'b00, rx} >= trial) begin
					rx = 49'({2'b00, rx} - trial);
					bx = {bx[16:0], 1'b1};
				end else begin
					bx = {bx[16:0], 1'b0};
				end
				if ({2'b00, ry} >= trial) begin
					ry = 49'({2'b00, ry} - trial);
					by = {by[16:0], 1'b1};
				end else begin
					by = {by[16:0], 1'b0};
				end
			end
			remx_nx[st] = rx;
			remy_nx[st] = ry;
			qx_nx[st]   = bx;
			qy_nx[st]   = by;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int st = 0; st < NST; st++) begin
				remx_s[st] <= remx_nx[st];
				remy_s[st] <= remy_nx[st];
				qx_s[st]   <= qx_nx[st];
				qy_s[st]   <= qy_nx[st];
				if (st == 0) begin
					len_s[st]  <= in_len;
					side_s[st] <= in_side;
				end else begin
					len_s[st]  <= len_s[st-1];
					side_s[st] <= side_s[st-1];
				end
			end
		end
	end

	assign out_vld  = vld_s[NST-1];
	assign qx       = qx_s[NST-1][16:0];
	assign qy       = qy_s[NST-1][16:0];
	assign len      = len_s[NST-1];
	assign out_side = side_s[NST-1];

endmodule

@@ design/dsi_force.sv @@
// Force pipeline: closing speed, damping and elastic force, impulse scaling and output register.
module dsi_force import dsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_vld,
	input  logic [16:0] qx,
	input  logic [16:0] qy,
	input  logic [32:0] len,
	input  dsi_side_t   in_side,
	input  dsi_cfg_t    cfg,
	input  logic [28:0] kdiv,
	output logic        out_vld,
	output dsi_out_t    res
);

	localparam int unsigned NST = 10;
	localparam logic [34:0] CAP = 35'h4_0000_0000;

	typedef struct packed {
		logic signed [17:0] dir_x;
		logic signed [17:0] dir_y;
		logic               coin;
		dsi_vel_t           vel;
	} keep_t;

	function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
		if (v > 37'sh0_7FFF_FFFF) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < -37'sh0_8000_0000) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	logic [NST-1:0] vld_s;

	keep_t              keep_s1, keep_s2, keep_s3, keep_s4, keep_s5;
	keep_t              keep_s6, keep_s7, keep_s8, keep_s9;
	logic signed [50:0] px_s1, py_s1;
	logic signed [33:0] e_s1;
	logic signed [29:0] k_s1;
	logic signed [35:0] dv_s2;
	logic signed [47:0] el_lo_s2;
	logic signed [46:0] el_hi_s2;
	logic signed [49:0] dm_lo_s3, dm_hi_s3;
	logic               clamp_s3;
	logic signed [47:0] elastic_s3, elastic_s4;
	logic signed [51:0] damp_s4;
	logic signed [47:0] force_s5;
	logic signed [42:0] cx_lo_s6, cy_lo_s6;
	logic signed [41:0] cx_hi_s6, cy_hi_s6;
	logic [47:0]        mx_s7, my_s7;
	logic               nx_s7, ny_s7, nx_s8, ny_s8;
	logic [54:0]        sx_hi_s8, sx_lo_s8, sy_hi_s8, sy_lo_s8;
	logic signed [35:0] dlx_s9, dly_s9;
	dsi_out_t           res_s10;

	// stage 1 inputs
	logic signed [17:0] dir_x, dir_y;
	logic [30:0]        rest;
	logic               clamp;
	logic [30:0]        coef;
	logic signed [51:0] dvsum;
	logic signed [63:0] el_full;
	logic signed [67:0] dm_full;
	logic signed [52:0] fsum;
	logic signed [66:0] cx_full, cy_full;
	logic signed [49:0] comp_x, comp_y;
	logic [63:0]        rx, ry;
	logic [34:0]        mag_x, mag_y;

	always_comb begin
		dir_x = in_side.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		dir_y = in_side.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		case (in_side.kind)
			KIND_HORIZ: rest = cfg.rest_h;
			KIND_VERT:  rest = cfg.rest_v;
			default:    rest = cfg.rest_d;
		endcase
		clamp = ({8'h00, cfg.damp, 1'b0} > {1'b0, cfg.mass});
		coef  = clamp ? cfg.mass : {8'h00, cfg.damp};

		dvsum   = px_s1 + py_s1;
		el_full = (el_hi_s2 <<< 17) + el_lo_s2;
		dm_full = (dm_hi_s3 <<< 18) + dm_lo_s3;
		fsum    = elastic_s4 + damp_s4;
		cx_full = (cx_hi_s6 <<< 24) + cx_lo_s6;
		cy_full = (cy_hi_s6 <<< 24) + cy_lo_s6;
		comp_x  = cx_full[65:16];
		comp_y  = cy_full[65:16];
		rx      = {1'b0, sx_hi_s8, 8'h00} + {25'h0, sx_lo_s8[54:16]};
		ry      = {1'b0, sy_hi_s8, 8'h00} + {25'h0, sy_lo_s8[54:16]};
		mag_x   = (rx > {29'h0, CAP}) ? CAP : rx[34:0];
		mag_y   = (ry > {29'h0, CAP}) ? CAP : ry[34:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: closing speed products, length error, stiffness pick
			keep_s1.dir_x <= dir_x;
			keep_s1.dir_y <= dir_y;
			keep_s1.coin  <= (len == '0);
			keep_s1.vel   <= in_side.vel;
			px_s1 <= $signed(in_side.dvx) * dir_x;
			py_s1 <= $signed(in_side.dvy) * dir_y;
			e_s1  <= $signed({1'b0, len}) - $signed({3'b000, rest});
			k_s1  <= (in_side.kind == KIND_DIAG_NEG) ? -$signed({1'b0, kdiv})
				: $signed({1'b0, cfg.stiff});

			// s2: closing speed, elastic partial products
			keep_s2  <= keep_s1;
			dv_s2    <= dvsum[51:16];
			el_lo_s2 <= $signed({1'b0, e_s1[16:0]}) * k_s1;
			el_hi_s2 <= $signed(e_s1[33:17]) * k_s1;

			// s3: elastic force, damping partial products
			keep_s3    <= keep_s2;
			elastic_s3 <= el_full[63:16];
			clamp_s3   <= clamp;
			dm_lo_s3   <= $signed({1'b0, dv_s2[17:0]}) * $signed({1'b0, coef});
			dm_hi_s3   <= $signed(dv_s2[35:18]) * $signed({1'b0, coef});

			// s4: damping force, halved mass when clamped
			keep_s4    <= keep_s3;
			elastic_s4 <= elastic_s3;
			damp_s4    <= clamp_s3 ? {dm_full[67], dm_full[67:17]} : dm_full[67:16];

			// s5: total force, saturated to 48 bits
			keep_s5 <= keep_s4;
			if (fsum > 53'sh0_7FFF_FFFF_FFFF) begin
				force_s5 <= 48'sh7FFF_FFFF_FFFF;
			end else if (fsum < -53'sh0_8000_0000_0000) begin
				force_s5 <= 48'sh8000_0000_0000;
			end else begin
				force_s5 <= fsum[47:0];
			end

			// s6: force along each axis, split products
			keep_s6  <= keep_s5;
			cx_lo_s6 <= keep_s5.dir_x * $signed({1'b0, force_s5[23:0]});
			cx_hi_s6 <= keep_s5.dir_x * $signed(force_s5[47:24]);
			cy_lo_s6 <= keep_s5.dir_y * $signed({1'b0, force_s5[23:0]});
			cy_hi_s6 <= keep_s5.dir_y * $signed(force_s5[47:24]);

			// s7: axis components as sign and magnitude
			keep_s7 <= keep_s6;
			nx_s7   <= comp_x[49];
			ny_s7   <= comp_y[49];
			mx_s7   <= comp_x[49] ? 48'(-comp_x) : comp_x[47:0];
			my_s7   <= comp_y[49] ? 48'(-comp_y) : comp_y[47:0];

			// s8: scale by the inverse mass, split products
			keep_s8  <= keep_s7;
			nx_s8    <= nx_s7;
			ny_s8    <= ny_s7;
			sx_hi_s8 <= mx_s7[47:24] * cfg.inv;
			sx_lo_s8 <= mx_s7[23:0] * cfg.inv;
			sy_hi_s8 <= my_s7[47:24] * cfg.inv;
			sy_lo_s8 <= my_s7[23:0] * cfg.inv;

			// s9: capped velocity change with its sign back
			keep_s9 <= keep_s8;
			dlx_s9  <= nx_s8 ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
			dly_s9  <= ny_s8 ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});

			// s10: output register; hold the velocities when the points coincide
			if (keep_s9.coin) begin
				res_s10.new_first_vel_x  <= keep_s9.vel.v1x;
				res_s10.new_first_vel_y  <= keep_s9.vel.v1y;
				res_s10.new_second_vel_x <= keep_s9.vel.v2x;
				res_s10.new_second_vel_y <= keep_s9.vel.v2y;
				res_s10.coincident       <= 1'b1;
			end else begin
				res_s10.new_first_vel_x  <= sat32(37'(keep_s9.vel.v1x) - 37'(dlx_s9));
				res_s10.new_first_vel_y  <= sat32(37'(keep_s9.vel.v1y) - 37'(dly_s9));
				res_s10.new_second_vel_x <= sat32(37'(keep_s9.vel.v2x) + 37'(dlx_s9));
				res_s10.new_second_vel_y <= sat32(37'(keep_s9.vel.v2y) + 37'(dly_s9));
				res_s10.coincident       <= 1'b0;
			end
		end
	end

	assign out_vld = vld_s[NST-1];
	assign res     = res_s10;

endmodule

@@ design/damped_spring_impulse_core.sv @@
// Top level of the damped spring impulse core: input stages, configuration and pipeline.
//
//   channel   direction  handshake                       payload
//   spring    in         spring_valid / spring_ready     dsi_in_t
//   update    out        update_valid / update_ready     dsi_out_t
//   cfg       in         cfg_we (no back-pressure)       cfg_index, cfg_wdata
//
// One spring enters per clock while no result is stalled; each result passes through
// 3 input stages, 17 root stages, 9 divide stages and 10 force stages.
// Most of the depth comes from the digit-pair root and the two-bit-per-stage divider.
// Reset clears every valid bit and loads the register reset values at once.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module damped_spring_impulse_core import dsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        spring_valid,
	output logic        spring_ready,
	input  dsi_in_t     spring,
	output logic        update_valid,
	input  logic        update_ready,
	output dsi_out_t    update,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_wdata
);

	dsi_cfg_t    cfg_q;
	logic [28:0] kdiv_q;
	logic        adv;

	logic        vld_s1, vld_s2, vld_s3;
	dsi_side_t   side_s1, side_s2, side_s3;
	logic [64:0] sqx_s2, sqy_s2;
	logic [65:0] sum_s3;

	dsi_side_t   side_in;
	logic [32:0] dx, dy;

	logic        sq_vld;
	logic [32:0] sq_root;
	dsi_side_t   sq_side;

	logic        dv_vld;
	logic [16:0] dv_qx, dv_qy;
	logic [32:0] dv_len;
	dsi_side_t   dv_side;

	// Advance every stage unless a finished result is waiting
	assign adv          = !update_valid || update_ready;
	assign spring_ready = adv;

	// Configuration registers, masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rest_h <= 31'd655360;
			cfg_q.rest_v <= 31'd655360;
			cfg_q.rest_d <= 31'd926819;
			cfg_q.stiff  <= 29'd32768000;
			cfg_q.damp   <= 23'd655360;
			cfg_q.mass   <= 31'd65536;
			cfg_q.inv    <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REST_H:    cfg_q.rest_h <= cfg_wdata;
				REG_REST_V:    cfg_q.rest_v <= cfg_wdata;
				REG_REST_D:    cfg_q.rest_d <= cfg_wdata;
				REG_STIFFNESS: cfg_q.stiff  <= cfg_wdata[28:0];
				REG_DAMPING:   cfg_q.damp   <= cfg_wdata[22:0];
				REG_MASS:      cfg_q.mass   <= cfg_wdata;
				REG_INV_MASS:  cfg_q.inv    <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// Tenth of the stiffness for the inverted diagonal, by reciprocal multiply.
	// Registered from the stiffness register; settles long before a spring taken after the write reaches the force stages.
	always_ff @(posedge clk) begin
		kdiv_q <= 29'(({35'h0, cfg_q.stiff} * RECIP10) >> RECIP10_SHIFT);
	end

	// Offsets, their magnitudes and the relative velocity
	always_comb begin
		dx = {spring.first_pos_x[31], spring.first_pos_x}
			- {spring.second_pos_x[31], spring.second_pos_x};
		dy = {spring.first_pos_y[31], spring.first_pos_y}
			- {spring.second_pos_y[31], spring.second_pos_y};
		side_in.kind    = spring.kind;
		side_in.sx      = dx[32];
		side_in.sy      = dy[32];
		side_in.ax      = dx[32] ? -dx : dx;
		side_in.ay      = dy[32] ? -dy : dy;
		side_in.dvx     = $signed({spring.first_vel_x[31], spring.first_vel_x})
			- $signed({spring.second_vel_x[31], spring.second_vel_x});
		side_in.dvy     = $signed({spring.first_vel_y[31], spring.first_vel_y})
			- $signed({spring.second_vel_y[31], spring.second_vel_y});
		side_in.vel.v1x = spring.first_vel_x;
		side_in.vel.v1y = spring.first_vel_y;
		side_in.vel.v2x = spring.second_vel_x;
		side_in.vel.v2y = spring.second_vel_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= spring_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// s1 holds the offsets, s2 the squares, s3 the full 66-bit sum
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			sqx_s2  <= {32'h0, side_s1.ax} * {32'h0, side_s1.ax};
			sqy_s2  <= {32'h0, side_s1.ay} * {32'h0, side_s1.ay};
			side_s3 <= side_s2;
			sum_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

	dsi_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (vld_s3),
		.radicand (sum_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// Unit direction: offset * 65536 / length, truncated toward zero
	dsi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (sq_vld),
		.in_len   (sq_root),
		.in_side  (sq_side),
		.out_vld  (dv_vld),
		.qx       (dv_qx),
		.qy       (dv_qy),
		.len      (dv_len),
		.out_side (dv_side)
	);

	dsi_force u_force (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (dv_vld),
		.qx      (dv_qx),
		.qy      (dv_qy),
		.len     (dv_len),
		.in_side (dv_side),
		.cfg     (cfg_q),
		.kdiv    (kdiv_q),
		.out_vld (update_valid),
		.res     (update)
	);

endmodule

@@ design/dsi_checker.sv @@
// Port-level checks of the damped spring impulse core, bound to the top level.
module dsi_checker import dsi_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     spring_ready,
	input logic     update_valid,
	input logic     update_ready,
	input dsi_out_t update
);

	// Reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !update_valid)
		else $error("result valid during reset");

	// Take a spring whenever the output side can move
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!update_valid || update_ready) |-> spring_ready)
		else $error("spring not taken with a free output");

	// A stalled result stops the whole pipeline
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(update_valid && !update_ready) |-> !spring_ready)
		else $error("spring taken while result stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(update_valid && !update_ready) |=> (update_valid && $stable(update)))
		else $error("stalled result changed");

endmodule

bind damped_spring_impulse_core dsi_checker u_dsi_checker (.*);

@@ tb/sv/damped_spring_impulse_core_tb.sv @@
// Self-checking testbench of the damped spring impulse core.
`timescale 1ns / 1ps

module damped_spring_impulse_core_tb;
	import dsi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        spring_valid;
	logic        spring_ready;
	dsi_in_t     spring;
	logic        update_valid;
	logic        update_ready;
	dsi_out_t    update;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [30:0] cfg_wdata;

	damped_spring_impulse_core DUT (
		.clk(clk), .arst_n(arst_n),
		.spring_valid(spring_valid), .spring_ready(spring_ready), .spring(spring),
		.update_valid(update_valid), .update_ready(update_ready), .update(update),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the register file
	logic [30:0] rest_h, rest_v, rest_d, mass, inv_mass;
	logic [28:0] stiffness;
	logic [22:0] damping_coef;

	dsi_in_t  pending_springs[$];
	dsi_out_t expected_updates[$];
	int       failures = 0;
	int       updates_seen = 0;
	int       coincident_seen = 0;
	int       springs_sent = 0;

	// Append one spring to the driver's queue
	function automatic void add_spring(dsi_in_t s);
		pending_springs = {pending_springs, s};
	endfunction

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// Floor shift of a wide signed value
	function automatic logic signed [127:0] fshr(logic signed [127:0] v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [127:0] sat(logic signed [127:0] v, logic signed [127:0] lim);
		if (v > lim) return lim;
		if (v < -lim - 1) return -lim - 1;
		return v;
	endfunction

	function automatic logic [63:0] root_of(logic [127:0] v);
		logic [127:0] r, bitv;
		r = 0;
		bitv = 128'd1 << 66;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r[63:0];
	endfunction

	// Velocity change along one axis, scaled by the inverse mass and capped
	function automatic logic signed [127:0] impulse(logic signed [127:0] comp);
		logic [127:0] mag, r;
		mag = comp < 0 ? -comp : comp;
		r = ((mag >> 24) * inv_mass << 8) + (((mag & 128'hFFFFFF) * inv_mass) >> 16);
		if (r > (128'd1 << 34)) r = 128'd1 << 34;
		return comp < 0 ? -$signed(r) : $signed(r);
	endfunction

	function automatic dsi_out_t spring_update(dsi_in_t s);
		dsi_out_t o;
		logic signed [127:0] dx, dy, len, dirx, diry, dv, damp, k, rest, el, tot_force;
		logic signed [127:0] dlx, dly, lim32;
		lim32 = 128'sh7FFFFFFF;
		dx = $signed(s.first_pos_x) - $signed(s.second_pos_x);
		dy = $signed(s.first_pos_y) - $signed(s.second_pos_y);
		len = $signed({64'd0, root_of(dx * dx + dy * dy)});
		if (len == 0) begin
			o.new_first_vel_x  = s.first_vel_x;
			o.new_first_vel_y  = s.first_vel_y;
			o.new_second_vel_x = s.second_vel_x;
			o.new_second_vel_y = s.second_vel_y;
			o.coincident = 1'b1;
			return o;
		end
		dirx = (dx * 65536) / len;
		diry = (dy * 65536) / len;
		dv = fshr(($signed(s.first_vel_x) - $signed(s.second_vel_x)) * dirx
			+ ($signed(s.first_vel_y) - $signed(s.second_vel_y)) * diry, 16);
		if (2 * {1'b0, damping_coef} > {1'b0, mass})
			damp = fshr(dv * $signed({97'd0, mass}), 17);
		else
			damp = fshr(dv * $signed({105'd0, damping_coef}), 16);
		case (s.kind)
			KIND_HORIZ: rest = $signed({97'd0, rest_h});
			KIND_VERT:  rest = $signed({97'd0, rest_v});
			default:    rest = $signed({97'd0, rest_d});
		endcase
		k = $signed({99'd0, stiffness});
		if (s.kind == KIND_DIAG_NEG) k = -(k / 10);
		el = fshr((len - rest) * k, 16);
		tot_force = sat(el + damp, (128'sd1 <<< 47) - 1);
		dlx = impulse(fshr(dirx * tot_force, 16));
		dly = impulse(fshr(diry * tot_force, 16));
		o.new_first_vel_x  = 32'(sat($signed(s.first_vel_x) - dlx, lim32));
		o.new_first_vel_y  = 32'(sat($signed(s.first_vel_y) - dly, lim32));
		o.new_second_vel_x = 32'(sat($signed(s.second_vel_x) + dlx, lim32));
		o.new_second_vel_y = 32'(sat($signed(s.second_vel_y) + dly, lim32));
		o.coincident = 1'b0;
		return o;
	endfunction

	// Driver: bursts of back-to-back transfers separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_valid <= 1'b0;
			spring <= '0;
		end else begin
			if (spring_valid && spring_ready) begin
				expected_updates = {expected_updates, spring_update(spring)};
				springs_sent++;
			end
			if (spring_valid && !spring_ready) begin
				// hold the item until it is taken
			end else if (gap_left > 0) begin
				gap_left--;
				spring_valid <= 1'b0;
			end else if (pending_springs.size() > 0) begin
				spring <= pending_springs.pop_front();
				spring_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end
			end else begin
				spring_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: alternate long open windows with bouts of random stalling
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_ready <= 1'b0;
		end else begin
			stall_phase = (stall_phase + 1) % 97;
			if (stall_phase < 40)
				update_ready <= 1'b1;
			else
				update_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	// Monitor: compare every transfer on the result side with the oldest expectation
	always @(posedge clk) begin
		dsi_out_t exp_u;
		if (arst_n && update_valid && update_ready) begin
			if (expected_updates.size() == 0) begin
				$display("%0t: unexpected update, actual %h", $time, update);
				failures++;
			end else begin
				exp_u = expected_updates.pop_front();
				updates_seen++;
				if (update.coincident) coincident_seen++;
				if (update.new_first_vel_x !== exp_u.new_first_vel_x)
					$display("%0t: new_first_vel_x expected %h actual %h", $time,
						exp_u.new_first_vel_x, update.new_first_vel_x);
				if (update.new_first_vel_y !== exp_u.new_first_vel_y)
					$display("%0t: new_first_vel_y expected %h actual %h", $time,
						exp_u.new_first_vel_y, update.new_first_vel_y);
				if (update.new_second_vel_x !== exp_u.new_second_vel_x)
					$display("%0t: new_second_vel_x expected %h actual %h", $time,
						exp_u.new_second_vel_x, update.new_second_vel_x);
				if (update.new_second_vel_y !== exp_u.new_second_vel_y)
					$display("%0t: new_second_vel_y expected %h actual %h", $time,
						exp_u.new_second_vel_y, update.new_second_vel_y);
				if (update.coincident !== exp_u.coincident)
					$display("%0t: coincident expected %b actual %b", $time,
						exp_u.coincident, update.coincident);
				if (update !== exp_u) failures++;
			end
		end
	end

	// Write one register on the port and in the shadow copy
	task automatic write_reg(logic [2:0] idx, logic [30:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_REST_H:    rest_h = val;
			REG_REST_V:    rest_v = val;
			REG_REST_D:    rest_d = val;
			REG_STIFFNESS: stiffness = val[28:0];
			REG_DAMPING:   damping_coef = val[22:0];
			REG_MASS:      mass = val;
			REG_INV_MASS:  inv_mass = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 2000000)) - 1000000;
			2: return $signed($urandom_range(0, 4000)) - 2000;
			3: return 32'sh7FFFFFFF - $urandom_range(0, 3);
			4: return 32'sh80000000 + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 200000)) - 100000;
		endcase
	endfunction

	// A spring near its rest shape, with small velocities, or raw noise
	function automatic dsi_in_t random_spring();
		dsi_in_t s;
		s.kind = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 3) != 0) begin
			s.second_pos_x = $signed($urandom_range(0, 4000000)) - 2000000;
			s.second_pos_y = $signed($urandom_range(0, 4000000)) - 2000000;
			s.first_pos_x = s.second_pos_x + $signed($urandom_range(0, 2000000)) - 1000000;
			s.first_pos_y = s.second_pos_y + $signed($urandom_range(0, 2000000)) - 1000000;
			if ($urandom_range(0, 15) == 0) begin
				s.first_pos_x = s.second_pos_x;
				s.first_pos_y = s.second_pos_y;
			end
			s.first_vel_x  = $signed($urandom_range(0, 400000)) - 200000;
			s.first_vel_y  = $signed($urandom_range(0, 400000)) - 200000;
			s.second_vel_x = $signed($urandom_range(0, 400000)) - 200000;
			s.second_vel_y = $signed($urandom_range(0, 400000)) - 200000;
		end else begin
			s.first_pos_x = rnd32(); s.first_pos_y = rnd32();
			s.first_vel_x = rnd32(); s.first_vel_y = rnd32();
			s.second_pos_x = rnd32(); s.second_pos_y = rnd32();
			s.second_vel_x = rnd32(); s.second_vel_y = rnd32();
		end
		return s;
	endfunction

	// Wait for every expectation, then for the pipeline to drain
	task automatic drain();
		while (pending_springs.size() > 0 || spring_valid || expected_updates.size() > 0)
			@(negedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic dsi_in_t make_spring(logic [1:0] k, int px, int py, int qx, int qy,
		int vx, int vy, int wx, int wy);
		dsi_in_t s;
		s.kind = k;
		s.first_pos_x = px; s.first_pos_y = py;
		s.second_pos_x = qx; s.second_pos_y = qy;
		s.first_vel_x = vx; s.first_vel_y = vy;
		s.second_vel_x = wx; s.second_vel_y = wy;
		return s;
	endfunction

	initial begin
		logic [30:0] cfg_set[7];
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		rest_h = 31'd655360; rest_v = 31'd655360; rest_d = 31'd926819;
		stiffness = 29'd32768000; damping_coef = 23'd655360;
		mass = 31'd65536; inv_mass = 31'd65536;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: each kind, coincident points, extremes and saturation
		for (int k = 0; k < 4; k++)
			add_spring(make_spring(2'(k), 700000, 0, 0, 0, 65536, -65536, 0, 0));
		add_spring(make_spring(KIND_VERT, 0, 655360, 0, 0, 0, 0, 0, 0));
		add_spring(make_spring(KIND_DIAG, 5, 5, 5, 5, 1, 2, 3, 4));
		add_spring(make_spring(KIND_HORIZ, -7, 9, -7, 9,
			32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
		add_spring(make_spring(KIND_DIAG, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
		add_spring(make_spring(KIND_DIAG_NEG, 32'h80000000, 0,
			32'h7FFFFFFF, 0, 0, 0, 0, 0));
		add_spring(make_spring(KIND_HORIZ, 1, 0, 0, 0, -1, 0, 1, 0));
		add_spring(make_spring(KIND_VERT, 0, 1, 0, 0, 0, 0, 0, 0));
		add_spring(make_spring(KIND_HORIZ, 65536, 0, 0, 0,
			32'h7FFFF000, 0, 32'h80001000, 0));
		add_spring(make_spring(KIND_DIAG, 3000000, -4000000, 0, 0,
			-900000, 800000, 700000, -600000));
		drain();

		// Configuration phases: defaults seen, now extremes and random settings
		for (int phase = 0; phase < 6; phase++) begin
			for (int r = 0; r < 7; r++) begin
				case (phase)
					0: cfg_set[r] = '1;
					1: cfg_set[r] = '0;
					default: cfg_set[r] = 31'($urandom);
				endcase
			end
			if (phase == 1) cfg_set[REG_MASS] = 31'd1;
			if (phase == 2) begin
				// damping below half the mass, so the unclamped path is taken
				cfg_set[REG_DAMPING] = 31'($urandom_range(0, 30000));
				cfg_set[REG_MASS] = 31'd65536;
				cfg_set[REG_INV_MASS] = 31'd65536;
				cfg_set[REG_STIFFNESS] = 31'd327680000;
			end
			if (phase == 3) cfg_set[REG_STIFFNESS] = 31'($urandom_range(0, 327680000));
			for (int r = 0; r < 7; r++)
				write_reg(3'(r), cfg_set[r]);
			write_reg(3'd7, 31'($urandom));
			repeat (70) add_spring(random_spring());
			drain();
		end

		$display("%0d springs driven, %0d updates checked (%0d coincident) over 7 register settings",
			springs_sent, updates_seen, coincident_seen);
		if (failures == 0 && expected_updates.size() == 0)
			$display("damped_spring_impulse_core_tb: PASS");
		else
			$display("damped_spring_impulse_core_tb: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("damped_spring_impulse_core_tb: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
design/dsi_pkg.sv
design/dsi_isqrt.sv
design/dsi_div.sv
design/dsi_force.sv
design/damped_spring_impulse_core.sv
design/dsi_checker.sv
tb/sv/damped_spring_impulse_core_tb.sv
